>>> sv/jtl_pkg.sv
// Package for the JSON token lexer: state, result and error codes,
// and the character class helpers. No dependencies.
`default_nettype none
package jtl_pkg;

	typedef enum logic [2:0] {
		ST_START = 3'd0,
		ST_NUM   = 3'd1,
		ST_STR   = 3'd2,
		ST_ESC   = 3'd3,
		ST_HEX   = 3'd4,
		ST_SEP   = 3'd5
	} lex_state_t;

	typedef enum logic [1:0] {
		K_CHAR = 2'd0,
		K_END  = 2'd1,
		K_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE     = 3'd0,
		E_NO_QUOTE = 3'd1,
		E_BAD_ESC  = 3'd2,
		E_BAD_HEX  = 3'd3,
		E_BAD_NUM  = 3'd4,
		E_NO_SEP   = 3'd5
	} err_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
	endfunction

	function automatic logic is_num_char(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h2E) || (c == 8'h65) ||
			(c == 8'h45) || (c == 8'h2D);
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_COMMA) || (c == CH_RBRACK);
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> sv/jtl_if.sv
// Valid/ready channel interfaces for the JSON token lexer: byte input
// and result output. Depends on nothing.
`default_nettype none
interface jtl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_req;
	logic       func;

	modport source (output valid, output byte_req, output func, input ready);
	modport sink (input valid, input byte_req, input func, output ready);
endinterface

interface jtl_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_out;
	logic       token_type;
	logic       separator;
	logic [2:0] error_code;

	modport source (output valid, output kind, output char_out, output token_type,
		output separator, output error_code, input ready);
	modport sink (input valid, input kind, input char_out, input token_type,
		input separator, input error_code, output ready);
endinterface
`default_nettype wire

>>> sv/json_token_lexer_core.sv
// JSON token lexer: one byte per transfer in, at most one result per byte out.
// A result is registered and is on the output in the cycle after its byte's transfer.
// Throughput: one byte per cycle; the output register keeps taking bytes while
// its result is taken in the same cycle. Reset clears the lexer to token start.
// Depends on jtl_pkg and jtl_if.
`default_nettype none
module json_token_lexer_core (
	input wire logic     clk,
	input wire logic     arst_n,
	jtl_byte_if.sink     byte_in,
	jtl_result_if.source token_out
);
	import jtl_pkg::*;

	lex_state_t state_q, state_d;
	logic [1:0] hex_cnt_q, hex_cnt_d;
	logic [7:0] hex_val_q, hex_val_d;
	logic       cur_type_q, cur_type_d;

	logic       out_valid_q;
	kind_t      out_kind_q;
	logic [7:0] out_char_q;
	logic       out_type_q;
	logic       out_sep_q;
	err_t       out_err_q;

	logic       emit;
	kind_t      o_kind;
	logic [7:0] o_char;
	logic       o_sep;
	err_t       o_err;
	logic       accept;
	logic [7:0] c;
	logic [4:0] hd;
	logic [7:0] hex_next;

	assign c        = byte_in.byte_req;
	assign hd       = hex_digit(c);
	assign hex_next = {hex_val_q[3:0], hd[3:0]};

	assign byte_in.ready = !out_valid_q || token_out.ready;
	assign accept        = byte_in.valid && byte_in.ready;

	always_comb begin
		state_d    = state_q;
		hex_cnt_d  = hex_cnt_q;
		hex_val_d  = hex_val_q;
		cur_type_d = cur_type_q;
		emit       = 1'b0;
		o_kind     = K_CHAR;
		o_char     = 8'd0;
		o_sep      = 1'b0;
		o_err      = E_NONE;
		case (state_q)
			ST_NUM: begin
				if (is_num_char(c)) begin
					emit   = 1'b1;
					o_char = c;
				end else if (is_blank(c)) begin
					state_d = ST_SEP;
				end else if (is_sep(c)) begin
					state_d = ST_START;
					emit    = 1'b1;
					o_kind  = K_END;
					o_sep   = (c == CH_RBRACK);
				end else begin
					emit   = 1'b1;
					o_kind = K_ERR;
					o_err  = E_BAD_NUM;
				end
			end
			ST_STR: begin
				if (c == CH_QUOTE) begin
					state_d = ST_SEP;
				end else if (c == CH_BSLASH) begin
					state_d = ST_ESC;
				end else begin
					emit   = 1'b1;
					o_char = c;
				end
			end
			ST_ESC: begin
				state_d = ST_STR;
				emit    = 1'b1;
				case (c)
					8'h72:      o_char = 8'h0D;
					8'h6E:      o_char = 8'h0A;
					8'h74:      o_char = 8'h09;
					CH_BSLASH:  o_char = CH_BSLASH;
					CH_QUOTE:   o_char = CH_QUOTE;
					8'h62:      o_char = 8'h08;
					8'h66:      o_char = 8'h0C;
					8'h75, 8'h55: begin
						state_d   = ST_HEX;
						hex_cnt_d = 2'd0;
						hex_val_d = 8'd0;
						emit      = 1'b0;
					end
					default: begin
						state_d = ST_START;
						o_kind  = K_ERR;
						o_err   = E_BAD_ESC;
					end
				endcase
			end
			ST_HEX: begin
				if (!hd[4]) begin
					emit   = 1'b1;
					o_kind = K_ERR;
					o_err  = E_BAD_HEX;
				end else if (hex_cnt_q == 2'd3) begin
					state_d   = ST_STR;
					hex_cnt_d = 2'd0;
					hex_val_d = 8'd0;
					emit      = 1'b1;
					o_char    = hex_next;
				end else begin
					hex_cnt_d = hex_cnt_q + 2'd1;
					hex_val_d = hex_next;
				end
			end
			ST_SEP: begin
				if (is_sep(c)) begin
					state_d = ST_START;
					emit    = 1'b1;
					o_kind  = K_END;
					o_sep   = (c == CH_RBRACK);
				end else if (!is_blank(c)) begin
					emit   = 1'b1;
					o_kind = K_ERR;
					o_err  = E_NO_SEP;
				end
			end
			default: begin
				state_d = ST_START;
				if (!is_blank(c)) begin
					cur_type_d = byte_in.func;
					if (byte_in.func) begin
						if (c == CH_QUOTE) begin
							state_d = ST_STR;
						end else begin
							emit   = 1'b1;
							o_kind = K_ERR;
							o_err  = E_NO_QUOTE;
						end
					end else if (is_num_char(c)) begin
						state_d = ST_NUM;
						emit    = 1'b1;
						o_char  = c;
					end else if (is_sep(c)) begin
						emit   = 1'b1;
						o_kind = K_END;
						o_sep  = (c == CH_RBRACK);
					end else begin
						emit   = 1'b1;
						o_kind = K_ERR;
						o_err  = E_BAD_NUM;
					end
				end
			end
		endcase
		// any error: back to token start, hex cleared
		if (emit && (o_kind == K_ERR)) begin
			state_d   = ST_START;
			hex_cnt_d = 2'd0;
			hex_val_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			hex_cnt_q   <= 2'd0;
			hex_val_q   <= 8'd0;
			cur_type_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			state_q     <= state_d;
			hex_cnt_q   <= hex_cnt_d;
			hex_val_q   <= hex_val_d;
			cur_type_q  <= cur_type_d;
			out_valid_q <= emit;
		end else if (token_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_kind_q <= o_kind;
			out_char_q <= o_char;
			out_type_q <= cur_type_d;
			out_sep_q  <= o_sep;
			out_err_q  <= o_err;
		end
	end

	assign token_out.valid      = out_valid_q;
	assign token_out.kind       = out_kind_q;
	assign token_out.char_out   = out_char_q;
	assign token_out.token_type = out_type_q;
	assign token_out.separator  = out_sep_q;
	assign token_out.error_code = out_err_q;

endmodule
`default_nettype wire

>>> sv/jtl_checker.sv
// Port-level checks for json_token_lexer_core, bound into every instance of that module.
// Depends on jtl_pkg and json_token_lexer_core.
`default_nettype none
module jtl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] char_out,
	input wire logic       separator,
	input wire logic [2:0] error_code
);
	import jtl_pkg::*;

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_CHAR) |-> (error_code == E_NONE) && !separator)
		else $error("char result carries error or separator");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_END) |-> (error_code == E_NONE) && (char_out == 8'd0))
		else $error("token end carries error or char");

	a_err_coded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_ERR) |->
		(error_code != E_NONE) && (char_out == 8'd0) && !separator)
		else $error("error result malformed");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == K_CHAR) || (kind == K_END) || (kind == K_ERR))
		else $error("illegal result kind");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_out) &&
		$stable(separator) && $stable(error_code))
		else $error("stalled result changed");

endmodule

bind json_token_lexer_core jtl_checker u_jtl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (token_out.valid),
	.out_ready  (token_out.ready),
	.kind       (token_out.kind),
	.char_out   (token_out.char_out),
	.separator  (token_out.separator),
	.error_code (token_out.error_code)
);
`default_nettype wire
